// ===== design/npc_pkg.sv =====
// Shared types, codes and constants of the nearest palette classifier.
package npc_pkg;

  localparam int unsigned DefPaletteDepth = 256;
  localparam int unsigned DefChannelBits  = 8;

  localparam int unsigned CountW     = 9;
  localparam int unsigned ThreshW    = 18;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 18;
  localparam int unsigned ColorW     = 32;
  localparam int unsigned AttrW      = 8;
  localparam int unsigned EntryW     = 8;
  localparam int unsigned NumForest  = 3;

  localparam logic [CountW-1:0]  CountReset  = 9'd21;
  localparam logic               FastReset   = 1'b1;
  localparam logic [ThreshW-1:0] ThreshReset = 18'd66;

  localparam logic [AttrW-1:0] ForestAttr   = 8'd9;
  localparam logic [AttrW-1:0] NoForestAttr = 8'd0;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PALETTE_COUNT   = 2'd0,
    REG_FAST_MODE       = 2'd1,
    REG_MATCH_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_HOLD
  } ctrl_state_e;

  typedef struct packed {
    logic write_entry;
    logic start;
    logic issue;
    logic first;
    logic last;
    logic load_out;
  } npc_cmd_t;

  typedef struct packed {
    logic done;
  } npc_stat_t;

  // Forest reference colours in 8-bit units, rescaled to cb bits with rounding.
  function automatic int unsigned forest_level(int unsigned f, int unsigned k,
                                               int unsigned cb);
    int unsigned v;
    v = 0;
    unique case (f)
      0: unique case (k) 0: v = 104; 1: v = 170; 2: v = 99;  default: v = 255; endcase
      1: unique case (k) 0: v = 28;  1: v = 99;  2: v = 48;  default: v = 255; endcase
      default:
         unique case (k) 0: v = 181; 1: v = 201; 2: v = 142; default: v = 255; endcase
    endcase
    return (v * ((1 << cb) - 1) + 127) / 255;
  endfunction

endpackage

// ===== design/npc_if.sv =====
// Valid/ready channel interfaces for pixel/load words and result words.
interface npc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_index;
  logic [7:0]  entry_attribute;
  logic [31:0] color_word;

  modport source (output valid, output operation, output entry_index,
                  output entry_attribute, output color_word, input ready);
  modport sink   (input valid, input operation, input entry_index,
                  input entry_attribute, input color_word, output ready);
endinterface

interface npc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] attribute;

  modport source (output valid, output attribute, input ready);
  modport sink   (input valid, input attribute, output ready);
endinterface

// ===== design/npc_dp.sv =====
// Datapath: palette memory, distance pipeline, best-match tracking, result register.
module npc_dp import npc_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = DefPaletteDepth,
  parameter int unsigned CHANNEL_BITS  = DefChannelBits,
  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1,
  localparam int unsigned IW = (AW > 2) ? AW : 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  npc_cmd_t           cmd_i,
  input  logic [IW-1:0]      idx_i,
  input  logic [EntryW-1:0]  entry_index_i,
  input  logic [AttrW-1:0]   entry_attribute_i,
  input  logic [ColorW-1:0]  color_word_i,
  input  logic               fast_mode_i,
  input  logic [ThreshW-1:0] threshold_i,
  output npc_stat_t          stat_o,
  output logic [AttrW-1:0]   attribute_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned XW = 4 * CB + ColorW;
  localparam int unsigned SQW = 2 * CB;
  localparam int unsigned SW = 2 * CB + 2;
  localparam int unsigned CW = (SW > ThreshW) ? SW : ThreshW;
  localparam int unsigned MW = AttrW + ColorW;

  logic [MW-1:0] mem [PALETTE_DEPTH];
  logic [MW-1:0] rd_q;
  logic          mem_we;

  logic [CB-1:0] forest_tab [NumForest][4];
  logic [CB-1:0] frst_q [4];

  logic [ColorW-1:0] pixel_q;
  logic              fast_q;

  logic v1_q, first1_q, last1_q;
  logic v2_q, first2_q, last2_q;
  logic done_q;

  logic [CB-1:0]    pix_ch [4];
  logic [CB-1:0]    cand_ch [4];
  logic [SQW-1:0]   sq_d [4];
  logic [SQW-1:0]   sq_q [4];
  logic [AttrW-1:0] attr2_q;

  logic [SW-1:0]    sum;
  logic [SW-1:0]    best_q;
  logic [AttrW-1:0] battr_q;
  logic             hit_q;
  logic             below;
  logic [AttrW-1:0] attr_out_q;

  for (genvar f = 0; f < NumForest; f++) begin : g_forest
    for (genvar k = 0; k < 4; k++) begin : g_chan
      localparam logic [CB-1:0] Level = CB'(forest_level(f, k, CB));
      assign forest_tab[f][k] = Level;
    end
  end

  assign mem_we = cmd_i.write_entry &&
                  ({1'b0, entry_index_i} < CountW'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[entry_index_i[AW-1:0]] <= {entry_attribute_i, color_word_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[idx_i[AW-1:0]];
    for (int k = 0; k < 4; k++) begin
      case (idx_i[1:0])
        2'd0:    frst_q[k] <= forest_tab[0][k];
        2'd1:    frst_q[k] <= forest_tab[1][k];
        default: frst_q[k] <= forest_tab[2][k];
      endcase
    end
    if (cmd_i.start) begin
      pixel_q <= color_word_i;
      fast_q  <= fast_mode_i;
    end
  end

  // Channel k sits at bit offset (3-k)*CB; bits beyond the colour word read as zero.
  always_comb begin
    logic [XW-1:0] pix_x;
    logic [XW-1:0] mem_x;
    pix_x = {{(4 * CB){1'b0}}, pixel_q};
    mem_x = {{(4 * CB){1'b0}}, rd_q[ColorW-1:0]};
    for (int k = 0; k < 4; k++) begin
      pix_ch[k]  = pix_x[(3 - k) * CB +: CB];
      cand_ch[k] = fast_q ? frst_q[k] : mem_x[(3 - k) * CB +: CB];
    end
  end

  always_comb begin
    logic [CB-1:0] diff;
    for (int k = 0; k < 4; k++) begin
      diff    = (pix_ch[k] > cand_ch[k]) ? (pix_ch[k] - cand_ch[k])
                                         : (cand_ch[k] - pix_ch[k]);
      sq_d[k] = SQW'(diff) * SQW'(diff);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      sq_q[k] <= sq_d[k];
    end
    attr2_q <= rd_q[MW-1:ColorW];
  end

  assign sum   = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
  assign below = CW'(sum) < CW'(threshold_i);

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      if (first2_q || (sum < best_q)) begin
        best_q  <= sum;
        battr_q <= attr2_q;
      end
      hit_q <= below | (hit_q & ~first2_q);
    end
    if (cmd_i.load_out) begin
      attr_out_q <= fast_q ? (hit_q ? ForestAttr : NoForestAttr) : battr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      v2_q     <= 1'b0;
      first2_q <= 1'b0;
      last2_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      v1_q     <= cmd_i.issue;
      first1_q <= cmd_i.first;
      last1_q  <= cmd_i.last;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      done_q   <= v2_q & last2_q;
    end
  end

  assign stat_o.done = done_q;
  assign attribute_o = attr_out_q;

endmodule

// ===== design/npc_ctrl.sv =====
// Controller: accepts words, sequences the palette or forest scan, owns result valid.
module npc_ctrl import npc_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = DefPaletteDepth,
  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1,
  localparam int unsigned IW = (AW > 2) ? AW : 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_operation_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [CountW-1:0] palette_count_i,
  input  logic              fast_mode_i,
  input  npc_stat_t         stat_i,
  output npc_cmd_t          cmd_o,
  output logic [IW-1:0]     idx_o
);

  ctrl_state_e       state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;
  logic [CountW-1:0] eff_count;
  logic [CountW-1:0] last_full;

  assign accept   = in_valid_i & (state_q == ST_IDLE);
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    if (palette_count_i == '0) begin
      eff_count = CountW'(1);
    end else if (palette_count_i > CountW'(PALETTE_DEPTH)) begin
      eff_count = CountW'(PALETTE_DEPTH);
    end else begin
      eff_count = palette_count_i;
    end
    last_full = eff_count - CountW'(1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && in_operation_i == OP_CLASSIFY) state_d = ST_SCAN;
      ST_SCAN: if (idx_q == last_q) state_d = ST_WAIT;
      ST_WAIT: begin
        if (stat_i.done) state_d = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    idx_d      = idx_q;
    last_d     = last_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (in_operation_i == OP_CLASSIFY) begin
            cmd_o.start = 1'b1;
            idx_d       = '0;
            last_d      = fast_mode_i ? IW'(NumForest - 1) : last_full[IW-1:0];
          end else begin
            cmd_o.write_entry = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        cmd_o.first = (idx_q == '0);
        cmd_o.last  = (idx_q == last_q);
        idx_d       = idx_q + IW'(1);
      end
      ST_WAIT: cmd_o.load_out = stat_i.done & out_free;
      ST_HOLD: cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign idx_o       = idx_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/nearest_palette_classifier_unit.sv =====
// Nearest palette classifier top level: configuration registers, controller and datapath.
// A load word writes one palette slot and gives no result. A pixel word gives one result:
// in full mode the N palette entries searched go, one entry a cycle, through the single
// distance pipeline (memory read, four squarers, sum and compare); in fast mode the three
// forest colours go through the same pipeline. A finished result waits in its output
// register while load words are still taken. The palette reads as undefined until each
// slot is written.
module nearest_palette_classifier_unit import npc_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = DefPaletteDepth,
  parameter int unsigned CHANNEL_BITS  = DefChannelBits,
  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1,
  localparam int unsigned IW = (AW > 2) ? AW : 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  npc_in_if.sink               in_ch,
  npc_out_if.source            out_ch,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  logic [CountW-1:0]  count_q;
  logic               fast_q;
  logic [ThreshW-1:0] thresh_q;
  npc_cmd_t           cmd;
  npc_stat_t          stat;
  logic [IW-1:0]      idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CountReset;
      fast_q   <= FastReset;
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PALETTE_COUNT:   count_q  <= cfg_wdata_i[CountW-1:0];
        REG_FAST_MODE:       fast_q   <= cfg_wdata_i[0];
        REG_MATCH_THRESHOLD: thresh_q <= cfg_wdata_i[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  npc_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_operation_i (in_ch.operation),
    .in_ready_o     (in_ch.ready),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .palette_count_i(count_q),
    .fast_mode_i    (fast_q),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .idx_o          (idx)
  );

  npc_dp #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .idx_i            (idx),
    .entry_index_i    (in_ch.entry_index),
    .entry_attribute_i(in_ch.entry_attribute),
    .color_word_i     (in_ch.color_word),
    .fast_mode_i      (fast_q),
    .threshold_i      (thresh_q),
    .stat_o           (stat),
    .attribute_o      (out_ch.attribute)
  );

endmodule

// ===== tb/npc_checker.sv =====
// Checker for the nearest palette classifier: watches the channels, predicts results, compares.
`timescale 1ns / 1ps

module npc_checker import npc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  npc_in_if                    in_ch,
  npc_out_if                   out_ch,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);

  // forest colours at 8 bits per channel, so no rescaling is needed
  localparam logic [ColorW-1:0] ForestRgba [NumForest] = '{
    32'h68AA63FF, 32'h1C6330FF, 32'hB5C98EFF
  };

  logic [ColorW-1:0]  pal_colour [DefPaletteDepth];
  logic [AttrW-1:0]   pal_attr   [DefPaletteDepth];
  logic [CountW-1:0]  count_q;
  logic               fast_q;
  logic [ThreshW-1:0] thresh_q;
  logic [AttrW-1:0]   attr_due_q [$];
  logic [AttrW-1:0]   attr_due;

  function automatic int unsigned colour_distance(logic [ColorW-1:0] a, logic [ColorW-1:0] b);
    int unsigned sum;
    int          diff;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      diff = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
      sum += diff * diff;
    end
    return sum;
  endfunction

  function automatic logic [AttrW-1:0] nearest_attribute(logic [ColorW-1:0] px);
    int unsigned      n;
    int unsigned      best;
    int unsigned      d;
    logic [AttrW-1:0] attr;
    if (fast_q) begin
      for (int f = 0; f < NumForest; f++) begin
        if (colour_distance(px, ForestRgba[f]) < int'(thresh_q)) return ForestAttr;
      end
      return NoForestAttr;
    end
    n = count_q;
    if (n == 0) n = 1;
    if (n > DefPaletteDepth) n = DefPaletteDepth;
    best = colour_distance(px, pal_colour[0]);
    attr = pal_attr[0];
    for (int i = 1; i < n; i++) begin
      d = colour_distance(px, pal_colour[i]);
      if (d < best) begin
        best = d;
        attr = pal_attr[i];
      end
    end
    return attr;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  = CountReset;
      fast_q   = FastReset;
      thresh_q = ThreshReset;
      attr_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_PALETTE_COUNT:   count_q  = cfg_wdata_i[CountW-1:0];
          REG_FAST_MODE:       fast_q   = cfg_wdata_i[0];
          REG_MATCH_THRESHOLD: thresh_q = cfg_wdata_i[ThreshW-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (attr_due_q.size() == 0) begin
          $error("attribute: no word expected, got %0d", out_ch.attribute);
          errors_o++;
        end else begin
          attr_due = attr_due_q.pop_front();
          if (out_ch.attribute !== attr_due) begin
            $error("attribute: expected %0d, got %0d", attr_due, out_ch.attribute);
            errors_o++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_LOAD) begin
          pal_colour[in_ch.entry_index] = in_ch.color_word;
          pal_attr[in_ch.entry_index]   = in_ch.entry_attribute;
        end else begin
          attr_due_q.push_back(nearest_attribute(in_ch.color_word));
        end
      end
    end
    pending_o = attr_due_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the nearest palette classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb import npc_pkg::*; ();

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned Settle     = 8;

  localparam logic [ColorW-1:0] ForestWord [NumForest] = '{
    32'h68AA63FF, 32'h1C6330FF, 32'hB5C98EFF
  };
  localparam logic [ColorW-1:0] CommonWord [8] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h80808080, 32'h68AA63FF,
    32'h1C6330FF, 32'hB5C98EFF, 32'hFF0000FF, 32'h00FF0000
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  cfg_reg_e            cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         src_idle_pct;
  int unsigned         snk_stall_pct;
  int unsigned         pending;
  int unsigned         errors;
  int unsigned         cycles;
  bit                  loaded [DefPaletteDepth];

  npc_in_if  in_ch ();
  npc_out_if out_ch ();

  nearest_palette_classifier_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  npc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[nearest_palette_classifier_unit] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic send_word(logic op, logic [EntryW-1:0] idx, logic [AttrW-1:0] attr,
                           logic [ColorW-1:0] colour);
    if (op == OP_LOAD) loaded[idx] = 1'b1;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= op;
    in_ch.entry_index     <= idx;
    in_ch.entry_attribute <= attr;
    in_ch.color_word      <= colour;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // drop valid, wait for every result word, then let trailing loads finish
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic set_config(logic [CountW-1:0] count, logic fast, logic [ThreshW-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PALETTE_COUNT;
    cfg_wdata <= CfgDataW'(count);
    @(negedge clk_i);
    cfg_index <= REG_FAST_MODE;
    cfg_wdata <= CfgDataW'(fast);
    @(negedge clk_i);
    cfg_index <= REG_MATCH_THRESHOLD;
    cfg_wdata <= CfgDataW'(thr);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [ColorW-1:0] jitter(logic [ColorW-1:0] base, int spread);
    logic [ColorW-1:0] w;
    int                c;
    for (int k = 0; k < 4; k++) begin
      c = int'(base[8*k +: 8]) + int'($urandom_range(2 * spread)) - spread;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      w[8*k +: 8] = c[7:0];
    end
    return w;
  endfunction

  function automatic logic [ColorW-1:0] pick_colour();
    case ($urandom_range(3))
      0:       return CommonWord[$urandom_range(7)];
      1:       return jitter(CommonWord[$urandom_range(7)], 6);
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned loaded_prefix();
    int unsigned n;
    n = 0;
    while (n < DefPaletteDepth && loaded[n]) n++;
    return n;
  endfunction

  initial begin
    int unsigned        prefix;
    int unsigned        spread;
    logic [CountW-1:0]  count;
    logic               fast;
    logic [ThreshW-1:0] thr;

    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_PALETTE_COUNT;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.operation       = OP_LOAD;
    in_ch.entry_index     = '0;
    in_ch.entry_attribute = '0;
    in_ch.color_word      = '0;
    src_idle_pct          = 0;
    snk_stall_pct         = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // forest test at reset settings: exact colours, threshold edges, far colours
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h68AA63FF);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h1C6330FF);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'hB5C98EFF);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h70AA63FF);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h70AB63FF);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h70AB64FF);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h00000000);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'hFFFFFFFF);
    // loads give no word; entries 1 and 2 tie
    send_word(OP_LOAD, 8'd0, 8'hA5, 32'h00000000);
    send_word(OP_LOAD, 8'd1, 8'h5A, 32'hFFFFFFFF);
    send_word(OP_LOAD, 8'd2, 8'h00, 32'hFFFFFFFF);
    send_word(OP_LOAD, 8'd3, 8'hFF, 32'h80808080);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h1C6330FF);
    settle();
    set_config(9'd4, 1'b0, ThreshReset);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'hFFFFFFFF);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h00000000);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h7F7F7F80);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h40404040);
    settle();
    set_config(9'd0, 1'b0, 18'd0);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'hFFFFFFFF);
    settle();
    set_config(9'd4, 1'b1, 18'd0);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h68AA63FF);
    settle();
    set_config(9'd4, 1'b1, 18'h3FFFF);
    send_word(OP_CLASSIFY, 8'd0, 8'd0, 32'h00000000);

    for (int ph = 0; ph < 36; ph++) begin
      settle();
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
        default: begin src_idle_pct = 38; snk_stall_pct = 38; end
      endcase
      if (ph == 12) begin
        for (int i = 0; i < DefPaletteDepth; i++) begin
          send_word(OP_LOAD, i[7:0], AttrW'($urandom_range(255)), pick_colour());
        end
        settle();
      end
      prefix = loaded_prefix();
      fast   = ($urandom_range(2) == 0);
      case ($urandom_range(4))
        0:       thr = '0;
        1:       thr = ThreshReset;
        2:       thr = '1;
        3:       thr = ThreshW'($urandom_range(4000));
        default: thr = ThreshW'($urandom_range(262143));
      endcase
      if (prefix == DefPaletteDepth && $urandom_range(4) == 0) begin
        case ($urandom_range(3))
          0:       count = 9'd0;
          1:       count = 9'd256;
          2:       count = 9'd511;
          default: count = CountW'($urandom_range(511, 257));
        endcase
      end else if ($urandom_range(5) == 0) begin
        count = CountW'($urandom_range(prefix, 1));
      end else begin
        count = CountW'($urandom_range(prefix < 16 ? prefix : 16, 1));
      end
      set_config(count, fast, thr);
      for (int n = 0; n < 32; n++) begin
        if ($urandom_range(9) < 3) begin
          send_word(OP_LOAD,
                    EntryW'(($urandom_range(9) < 7) ? $urandom_range(31) : $urandom_range(255)),
                    AttrW'($urandom_range(255)), pick_colour());
        end else if (fast && $urandom_range(2) != 0) begin
          case ($urandom_range(3))
            0:       spread = 1;
            1:       spread = 4;
            2:       spread = 8;
            default: spread = 40;
          endcase
          send_word(OP_CLASSIFY, EntryW'($urandom_range(255)), AttrW'($urandom_range(255)),
                    jitter(ForestWord[$urandom_range(2)], spread));
        end else begin
          send_word(OP_CLASSIFY, EntryW'($urandom_range(255)), AttrW'($urandom_range(255)),
                    pick_colour());
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("[nearest_palette_classifier_unit] OK");
    end else begin
      $display("[nearest_palette_classifier_unit] ERROR");
    end
    $finish;
  end

endmodule
